### hw/rtl/pud_pkg.sv
// Package for the percent URL decoder: request types, character constants,
// escape phase codes and the hex digit helper. No dependencies.
`default_nettype none

package pud_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ChPlus    = 8'h2B;  // '+'
  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChSpace   = 8'h20;  // ' '

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  // One decoded request between front and back: one or two bytes.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       fin;
  } pud_job_t;

  // {valid, value}: valid is set for 0-9, a-f, A-F only.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h00;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/percent_url_decoder.sv
// Top level of the percent URL decoder: front end, request queue, back end.
// Depends on pud_pkg, pud_front, pud_queue and pud_back.
`default_nettype none

// Lenient URL percent decoder on a byte stream. '+' becomes a space, '%'
// with a hex digit and one more byte becomes one byte, and a '%' with no
// hex digit after it or cut short passes through literally; tlast marks a
// string's end and goes to its last decoded byte. One input byte is taken
// per cycle. Most bytes give one output byte, escape bytes none, and the
// byte after a literal '%' may give two, sent one after the other by the
// back end. A queue of QUEUE_DEPTH requests sits between the front end and
// the output register, so the input stalls only when it is full; one byte
// per cycle holds while the output is ready and two-byte results are rare.
module percent_url_decoder
  import pud_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // is_final
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // out_final
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  pud_job_t       push_job, pop_job;
  logic           push, pop, q_full, q_empty, hold_valid;
  logic [CW-1:0]  q_count;

  pud_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_final (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  pud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  pud_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_final  (out_tlast),
    .hold_valid (hold_valid)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("request queue count above depth");

  a_hold_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid |-> out_tvalid)
    else $error("second byte pending without an output byte");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

### hw/rtl/pud_front.sv
// Front end of the percent URL decoder: accepts input bytes, tracks the
// escape state and forms decoded requests. Depends on pud_pkg.
`default_nettype none

module pud_front
  import pud_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic     in_final,
  input  wire logic     q_full,
  output logic          push,
  output pud_job_t      push_job
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] digit_r, digit_nxt;
  logic [1:0] n;
  logic [4:0] hv;
  logic       accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign hv       = hex_decode(in_byte);

  always_comb begin
    phase_nxt    = PH_IDLE;
    digit_nxt    = digit_r;
    n            = 2'd0;
    push_job.b0  = in_byte;
    push_job.b1  = in_byte;
    case (phase_r)
      PH_PCT: begin
        if (hv[4] && !in_final) begin
          phase_nxt = PH_DIG;
          digit_nxt = hv[3:0];
        end else if (hv[4]) begin
          n           = 2'd2;
          push_job.b0 = ChPercent;
        end else begin
          n           = 2'd2;
          push_job.b0 = ChPercent;
          if (in_byte == ChPlus) begin
            push_job.b1 = ChSpace;
          end else if (in_byte == ChPercent) begin
            // a fresh escape; only flushed if the string ends here
            if (!in_final) begin
              n         = 2'd1;
              phase_nxt = PH_PCT;
            end
          end
        end
      end
      PH_DIG: begin
        n           = 2'd1;
        push_job.b0 = hv[4] ? {digit_r, hv[3:0]} : {4'h0, digit_r};
        digit_nxt   = 4'h0;
      end
      default: begin
        n = 2'd1;
        if (in_byte == ChPlus) begin
          push_job.b0 = ChSpace;
        end else if (in_byte == ChPercent && !in_final) begin
          n         = 2'd0;
          phase_nxt = PH_PCT;
        end
      end
    endcase
    if (in_final) begin
      phase_nxt = PH_IDLE;
      digit_nxt = 4'h0;
    end
    push_job.two = (n == 2'd2);
    push_job.fin = in_final;
    push         = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= 4'h0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pud_queue.sv
// Short request queue between the decoder front and back ends.
// Depends on pud_pkg for the request type.
`default_nettype none

module pud_queue
  import pud_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire pud_job_t               push_job,
  input  wire logic                   pop,
  output pud_job_t                    pop_job,
  output logic                        full,
  output logic                        empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pud_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign pop_job = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pud_back.sv
// Back end of the percent URL decoder: drains requests from the queue and
// drives the output register, one byte per cycle while the output is ready. Depends on pud_pkg.
`default_nettype none

module pud_back
  import pud_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire pud_job_t pop_job,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    out_byte,
  output logic          out_final,
  output logic          hold_valid
);

  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       of_r, of_nxt;
  logic       hv_r, hv_nxt;
  logic [7:0] hb_r, hb_nxt;
  logic       hf_r, hf_nxt;
  logic       load;

  assign load = ~ov_r | out_ready;

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    of_nxt = of_r;
    hv_nxt = hv_r;
    hb_nxt = hb_r;
    hf_nxt = hf_r;
    pop    = 1'b0;
    if (load) begin
      if (hv_r) begin
        // second byte of a two-byte request
        ov_nxt = 1'b1;
        ob_nxt = hb_r;
        of_nxt = hf_r;
        hv_nxt = 1'b0;
      end else if (!q_empty) begin
        pop    = 1'b1;
        ov_nxt = 1'b1;
        ob_nxt = pop_job.b0;
        of_nxt = pop_job.fin & ~pop_job.two;
        hv_nxt = pop_job.two;
        hb_nxt = pop_job.b1;
        hf_nxt = pop_job.fin;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    of_r <= of_nxt;
    hb_r <= hb_nxt;
    hf_r <= hf_nxt;
  end

  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign out_final  = of_r;
  assign hold_valid = hv_r;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Testbench for percent_url_decoder: directed and random encoded strings,
// checked byte for byte against a decoder model held in a scoreboard class.
// Depends on pud_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;
  import pud_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  class url_decode_scoreboard;
    phase_t      esc;
    logic [3:0]  hi_digit;
    dec_byte_t   pending[$];
    int          errors;
    int          reqs_in;
    int          bytes_out;
    int          double_count;

    function new();
      esc = PH_IDLE;
      hi_digit = 4'h0;
      errors = 0;
      reqs_in = 0;
      bytes_out = 0;
      double_count = 0;
    endfunction

    // {is_hex, value}
    function logic [4:0] digit_of(logic [7:0] c);
      logic [4:0] r;
      r = 5'h00;
      case (c) inside
        [8'h30:8'h39]: r = {1'b1, c[3:0]};
        [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'h9};
        default: r = 5'h00;
      endcase
      return r;
    endfunction

    function void emit(logic [7:0] b);
      dec_byte_t t;
      t.data = b;
      t.last = 1'b0;
      pending = {pending, t};
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == ChPlus) begin
        emit(ChSpace);
      end else if (b == ChPercent) begin
        esc = PH_PCT;
      end else begin
        emit(b);
      end
    endfunction

    function void note_input(logic [7:0] b, logic fin);
      int         start;
      logic [4:0] d;
      dec_byte_t  t;
      start = pending.size();
      d = digit_of(b);
      reqs_in++;
      case (esc)
        PH_PCT: begin
          if (d[4] && !fin) begin
            hi_digit = d[3:0];
            esc = PH_DIG;
          end else if (d[4]) begin
            emit(ChPercent);
            emit(b);
            esc = PH_IDLE;
          end else begin
            // not an escape after all: '%' goes out, byte is reparsed
            emit(ChPercent);
            esc = PH_IDLE;
            plain_byte(b);
          end
        end
        PH_DIG: begin
          emit(d[4] ? {hi_digit, d[3:0]} : {4'h0, hi_digit});
          esc = PH_IDLE;
          hi_digit = 4'h0;
        end
        default: begin
          esc = PH_IDLE;
          plain_byte(b);
        end
      endcase
      if (fin) begin
        if (esc == PH_PCT) begin
          emit(ChPercent);
        end
        esc = PH_IDLE;
        hi_digit = 4'h0;
        if (pending.size() > start) begin
          t = pending.pop_back();
          t.last = 1'b1;
          pending = {pending, t};
        end
      end
      if (pending.size() - start == 2) begin
        double_count++;
      end
    endfunction

    function void check_result(logic [7:0] b, logic fin);
      dec_byte_t t;
      bytes_out++;
      if (pending.size() == 0) begin
        $error("unexpected output byte %h (last %b)", b, fin);
        errors++;
      end else begin
        t = pending.pop_front();
        if (t.data !== b) begin
          $error("out_byte: expected %h, got %h", t.data, b);
          errors++;
        end
        if (t.last !== fin) begin
          $error("out_final: expected %b, got %b", t.last, fin);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // is_final
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;          // out_final

  int send_idle_pct = 0;
  int stall_pct = 0;
  int strings_sent = 0;

  url_decode_scoreboard sb = new();

  percent_url_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tlast);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
    strings_sent++;
  endtask

  function automatic logic [7:0] rand_hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  task automatic send_random_string(output int n_bytes);
    logic [7:0] chars[$];
    int         tokens;
    int         r;
    tokens = $urandom_range(1, 8);
    for (int i = 0; i < tokens; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        chars = {chars, ChPercent};
        chars = {chars, rand_hex_char()};
        chars = {chars, rand_hex_char()};
      end else if (r < 45) begin
        chars = {chars, ChPlus};
      end else if (r < 55) begin
        chars = {chars, ChPercent};
      end else if (r < 65) begin
        chars = {chars, rand_hex_char()};
      end else begin
        chars = {chars, 8'($urandom)};
      end
    end
    for (int i = 0; i < chars.size(); i++) begin
      send_byte(chars[i], i == chars.size() - 1);
    end
    n_bytes = chars.size();
    strings_sent++;
  endtask

  // Hold the request side idle until every decoded byte has come out, then set the idle and stall percentages.
  task automatic drain_and_set(input int idle_pct, input int stall);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    @(negedge clk);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int sent;
    int n;
    idle_tab = '{0, 59, 0, 36};
    stall_tab = '{0, 0, 59, 36};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("a+b");
    send_text("%41");
    send_text("%4g");   // second digit not hex: first digit alone
    send_text("%zF");   // not hex after percent
    send_text("%+");    // not hex, then reparsed as space, at the end
    send_text("%");     // lone percent at the end
    send_text("%c");    // percent too near the end, two bytes out
    send_text("%aF");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    strings_sent++;
    send_text("%%4");

    for (int p = 0; p < 4; p++) begin
      drain_and_set(idle_tab[p], stall_tab[p]);
      sent = 0;
      while (sent < 350) begin
        send_random_string(n);
        sent += n;
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d strings, %0d input bytes, %0d decoded bytes checked",
             strings_sent, sb.reqs_in, sb.bytes_out);
    $display("tb: %0d requests gave two bytes; sender and receiver idling in four mixes",
             sb.double_count);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pud_pkg.sv
hw/rtl/pud_front.sv
hw/rtl/pud_queue.sv
hw/rtl/pud_back.sv
hw/rtl/percent_url_decoder.sv
tb/sv/tb.sv
